/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file of the address mapper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define PBPI_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Clocked assertion that is also checked during reset.
`define PBPI_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/pbpi_pkg.sv */
// Package with the shared constants, register codes and stage types of the address mapper.
`default_nettype none

package pbpi_pkg;

    localparam int ADDR_WIDTH_DEF = 48;
    localparam int PA_WIDTH       = 48;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 5;

    localparam int PAGE_BIT       = 12;
    localparam int XOR_BASE_BIT   = 17;
    localparam int XOR_BITS       = 11;

    localparam int CH_W  = 4;
    localparam int RK_W  = 4;
    localparam int BG_W  = 4;
    localparam int BK_W  = 4;
    localparam int ROW_W = 24;
    localparam int COL_W = 12;

    localparam logic [3:0] TX_OFFSET_RST      = 4'd6;
    localparam logic [2:0] CHANNEL_BITS_RST   = 3'd0;
    localparam logic [2:0] RANK_BITS_RST      = 3'd1;
    localparam logic [2:0] BANKGROUP_BITS_RST = 3'd2;
    localparam logic [2:0] BANK_BITS_RST      = 3'd2;
    localparam logic [4:0] ROW_BITS_RST       = 5'd16;
    localparam logic [3:0] COLUMN_BITS_RST    = 4'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TX_OFFSET,
        CFG_CHANNEL_BITS,
        CFG_RANK_BITS,
        CFG_BANKGROUP_BITS,
        CFG_BANK_BITS,
        CFG_ROW_BITS,
        CFG_COLUMN_BITS
    } t_cfg_idx;

    // Field offsets and masks derived from the configuration registers.
    typedef struct packed {
        logic [2:0]       bgb;
        logic [2:0]       off_cl;
        logic [4:0]       off_bg;
        logic [4:0]       off_bk;
        logic [5:0]       off_hi;
        logic [5:0]       off_rk;
        logic [5:0]       off_rw;
        logic [3:0]       c1;
        logic [CH_W-1:0]  m_ch;
        logic [COL_W-1:0] m_cl;
        logic [BG_W-1:0]  m_bg;
        logic [BK_W-1:0]  m_bk;
        logic [COL_W-1:0] m_hi;
        logic [RK_W-1:0]  m_rk;
        logic [ROW_W-1:0] m_rw;
    } t_map;

    // Raw field slices handed from the slicing stage to the merge stage.
    typedef struct packed {
        logic [CH_W-1:0]  ch;
        logic [COL_W-1:0] cl;
        logic [BG_W-1:0]  bg;
        logic [BK_W-1:0]  bk;
        logic [COL_W-1:0] hi;
        logic [RK_W-1:0]  rk;
        logic [ROW_W-1:0] rw;
        logic [BG_W-1:0]  xbg;
        logic [BK_W-1:0]  xbk;
    } t_fields;

endpackage

`default_nettype wire

/* rtl/core/pbpi_cfg.sv */
// Configuration registers and the field offsets and masks derived from them.
`default_nettype none

module pbpi_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [pbpi_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [pbpi_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output logic [3:0]                          o_tx,
    output pbpi_pkg::t_map                      o_map
);
    import pbpi_pkg::*;

    logic [3:0] r_tx;
    logic [2:0] r_chb;
    logic [2:0] r_rkb;
    logic [2:0] r_bgb;
    logic [2:0] r_bkb;
    logic [4:0] r_rwb;
    logic [3:0] r_colb;
    t_map       r_map;
    t_map       n_map;

    function automatic logic [ROW_W-1:0] lmask(input logic [4:0] n);
        logic [ROW_W:0] t;
        t = ((ROW_W+1)'(1) << n) - (ROW_W+1)'(1);
        if (n >= 5'(ROW_W)) begin
            lmask = '1;
        end else begin
            lmask = t[ROW_W-1:0];
        end
    endfunction

    function automatic t_map derive(input logic [3:0] tx, input logic [2:0] chb,
                                    input logic [2:0] rkb, input logic [2:0] bgb,
                                    input logic [2:0] bkb, input logic [4:0] rwb,
                                    input logic [3:0] colb);
        t_map       m;
        logic [5:0] sum;
        logic [3:0] c1raw;
        logic [3:0] c1;
        logic [3:0] c2;
        logic [ROW_W-1:0] mc1;
        logic [ROW_W-1:0] mc2;
        sum = 6'(chb) + 6'(bgb) + 6'(bkb) + 6'(tx);
        if (sum >= 6'(PAGE_BIT)) begin
            c1raw = 4'd0;
        end else begin
            c1raw = 4'(6'(PAGE_BIT) - sum);
        end
        c1 = (c1raw > colb) ? colb : c1raw;
        c2 = colb - c1;
        mc1 = lmask(5'(c1));
        mc2 = lmask(5'(c2));
        m.bgb    = bgb;
        m.off_cl = chb;
        m.off_bg = 5'(chb) + 5'(c1);
        m.off_bk = m.off_bg + 5'(bgb);
        m.off_hi = 6'(m.off_bk) + 6'(bkb);
        m.off_rk = m.off_hi + 6'(c2);
        m.off_rw = m.off_rk + 6'(rkb);
        m.c1     = c1;
        m.m_ch   = CH_W'(lmask(5'(chb)));
        m.m_cl   = mc1[COL_W-1:0];
        m.m_bg   = BG_W'(lmask(5'(bgb)));
        m.m_bk   = BK_W'(lmask(5'(bkb)));
        m.m_hi   = mc2[COL_W-1:0];
        m.m_rk   = RK_W'(lmask(5'(rkb)));
        m.m_rw   = lmask(rwb);
        derive = m;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx   <= TX_OFFSET_RST;
            r_chb  <= CHANNEL_BITS_RST;
            r_rkb  <= RANK_BITS_RST;
            r_bgb  <= BANKGROUP_BITS_RST;
            r_bkb  <= BANK_BITS_RST;
            r_rwb  <= ROW_BITS_RST;
            r_colb <= COLUMN_BITS_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TX_OFFSET:      r_tx   <= i_cfg_wdata[3:0];
                CFG_CHANNEL_BITS:   r_chb  <= i_cfg_wdata[2:0];
                CFG_RANK_BITS:      r_rkb  <= i_cfg_wdata[2:0];
                CFG_BANKGROUP_BITS: r_bgb  <= i_cfg_wdata[2:0];
                CFG_BANK_BITS:      r_bkb  <= i_cfg_wdata[2:0];
                CFG_ROW_BITS:       r_rwb  <= i_cfg_wdata[4:0];
                CFG_COLUMN_BITS:    r_colb <= i_cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_map = derive(r_tx, r_chb, r_rkb, r_bgb, r_bkb, r_rwb, r_colb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map <= derive(TX_OFFSET_RST, CHANNEL_BITS_RST, RANK_BITS_RST,
                            BANKGROUP_BITS_RST, BANK_BITS_RST, ROW_BITS_RST,
                            COLUMN_BITS_RST);
        end else begin
            r_map <= n_map;
        end
    end

    assign o_tx  = r_tx;
    assign o_map = r_map;

endmodule

`default_nettype wire

/* rtl/core/pbpi_align.sv */
// First pipeline stage: trims the address, drops the transfer offset and keeps the XOR bits.
`default_nettype none

module pbpi_align #(
    parameter int ADDR_WIDTH = pbpi_pkg::ADDR_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic [pbpi_pkg::PA_WIDTH-1:0]  i_addr,
    input  wire logic [3:0]                    i_tx,
    output logic                               o_valid,
    output logic [ADDR_WIDTH-1:0]              o_a,
    output logic [pbpi_pkg::XOR_BITS-1:0]      o_x
);
    import pbpi_pkg::*;

    logic [PA_WIDTH+ADDR_WIDTH-1:0] ext;
    logic [ADDR_WIDTH-1:0]          raw;
    logic                           r_valid;
    logic [ADDR_WIDTH-1:0]          r_a;
    logic [XOR_BITS-1:0]            r_x;

    assign ext = {{ADDR_WIDTH{1'b0}}, i_addr};
    assign raw = ext[ADDR_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= raw >> i_tx;
            r_x <= raw[XOR_BASE_BIT +: XOR_BITS];
        end
    end

    assign o_valid = r_valid;
    assign o_a     = r_a;
    assign o_x     = r_x;

endmodule

`default_nettype wire

/* rtl/core/pbpi_slice.sv */
// Second pipeline stage: cuts the field slices out of the aligned address.
`default_nettype none

module pbpi_slice #(
    parameter int ADDR_WIDTH = pbpi_pkg::ADDR_WIDTH_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_valid,
    input  wire logic [ADDR_WIDTH-1:0]     i_a,
    input  wire logic [pbpi_pkg::XOR_BITS-1:0] i_x,
    input  wire pbpi_pkg::t_map            i_map,
    output logic                           o_valid,
    output pbpi_pkg::t_fields              o_f
);
    import pbpi_pkg::*;

    logic    r_valid;
    t_fields r_f;
    t_fields n_f;

    always_comb begin
        n_f.ch  = CH_W'(i_a);
        n_f.cl  = COL_W'(i_a >> i_map.off_cl);
        n_f.bg  = BG_W'(i_a >> i_map.off_bg);
        n_f.bk  = BK_W'(i_a >> i_map.off_bk);
        n_f.hi  = COL_W'(i_a >> i_map.off_hi);
        n_f.rk  = RK_W'(i_a >> i_map.off_rk);
        n_f.rw  = ROW_W'(i_a >> i_map.off_rw);
        n_f.xbg = i_x[BG_W-1:0];
        n_f.xbk = BK_W'(i_x >> i_map.bgb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f <= n_f;
        end
    end

    assign o_valid = r_valid;
    assign o_f     = r_f;

endmodule

`default_nettype wire

/* rtl/core/pbpi_merge.sv */
// Third pipeline stage: masks, permutes and joins the fields into the output indices.
`default_nettype none

module pbpi_merge (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire pbpi_pkg::t_fields           i_f,
    input  wire pbpi_pkg::t_map              i_map,
    output logic                             o_valid,
    output logic [pbpi_pkg::CH_W-1:0]        o_channel_index,
    output logic [pbpi_pkg::RK_W-1:0]        o_rank_index,
    output logic [pbpi_pkg::BG_W-1:0]        o_bankgroup_index,
    output logic [pbpi_pkg::BK_W-1:0]        o_bank_index,
    output logic [pbpi_pkg::ROW_W-1:0]       o_row_index,
    output logic [pbpi_pkg::COL_W-1:0]       o_column_index
);
    import pbpi_pkg::*;

    logic             r_valid;
    logic [CH_W-1:0]  r_ch;
    logic [RK_W-1:0]  r_rk;
    logic [BG_W-1:0]  r_bg;
    logic [BK_W-1:0]  r_bk;
    logic [ROW_W-1:0] r_rw;
    logic [COL_W-1:0] r_col;
    logic [COL_W-1:0] col_lo;
    logic [COL_W-1:0] col_hi;

    assign col_lo = i_f.cl & i_map.m_cl;
    assign col_hi = (i_f.hi & i_map.m_hi) << i_map.c1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ch  <= i_f.ch & i_map.m_ch;
            r_rk  <= i_f.rk & i_map.m_rk;
            r_bg  <= (i_f.bg ^ i_f.xbg) & i_map.m_bg;
            r_bk  <= (i_f.bk ^ i_f.xbk) & i_map.m_bk;
            r_rw  <= i_f.rw & i_map.m_rw;
            r_col <= col_lo | col_hi;
        end
    end

    assign o_valid           = r_valid;
    assign o_channel_index   = r_ch;
    assign o_rank_index      = r_rk;
    assign o_bankgroup_index = r_bg;
    assign o_bank_index      = r_bk;
    assign o_row_index       = r_rw;
    assign o_column_index    = r_col;

endmodule

`default_nettype wire

/* rtl/core/pbpi_dram_address_mapper_top.sv */
// Top level of the DRAM address mapper with permutation-based page interleaving.
`default_nettype none

// The mapper turns one byte address into channel, rank, bank group, bank, row and
// column and accepts a new word in every cycle while o_stall is low; each word passes
// through the three register stages (align, slice, merge). A stall from the output
// holds the merge stage and each occupied stage whose successor is held, while words
// still move into empty stages, so the input stall rises only when all three stages
// hold a word. Configuration writes take effect for words accepted on the following
// cycle and must be made while the pipeline is empty.
module pbpi_dram_address_mapper_top #(
    parameter int ADDR_WIDTH = pbpi_pkg::ADDR_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [pbpi_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [pbpi_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [pbpi_pkg::PA_WIDTH-1:0]    i_physical_address,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [pbpi_pkg::CH_W-1:0]            o_channel_index,
    output logic [pbpi_pkg::RK_W-1:0]            o_rank_index,
    output logic [pbpi_pkg::BG_W-1:0]            o_bankgroup_index,
    output logic [pbpi_pkg::BK_W-1:0]            o_bank_index,
    output logic [pbpi_pkg::ROW_W-1:0]           o_row_index,
    output logic [pbpi_pkg::COL_W-1:0]           o_column_index
);
    import pbpi_pkg::*;

    logic                  en1;
    logic                  en2;
    logic                  en3;
    logic                  v1;
    logic                  v2;
    logic                  v3;
    logic [3:0]            tx;
    t_map                  map;
    logic [ADDR_WIDTH-1:0] s1_a;
    logic [XOR_BITS-1:0]   s1_x;
    t_fields               s2_f;

    assign en3     = !v3 || !i_stall;
    assign en2     = !v2 || en3;
    assign en1     = !v1 || en2;
    assign o_stall = !en1;
    assign o_valid = v3;

    pbpi_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_tx        (tx),
        .o_map       (map)
    );

    pbpi_align #(.ADDR_WIDTH(ADDR_WIDTH)) u_align (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en1),
        .i_valid (i_valid),
        .i_addr  (i_physical_address),
        .i_tx    (tx),
        .o_valid (v1),
        .o_a     (s1_a),
        .o_x     (s1_x)
    );

    pbpi_slice #(.ADDR_WIDTH(ADDR_WIDTH)) u_slice (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en2),
        .i_valid (v1),
        .i_a     (s1_a),
        .i_x     (s1_x),
        .i_map   (map),
        .o_valid (v2),
        .o_f     (s2_f)
    );

    pbpi_merge u_merge (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (en3),
        .i_valid           (v2),
        .i_f               (s2_f),
        .i_map             (map),
        .o_valid           (v3),
        .o_channel_index   (o_channel_index),
        .o_rank_index      (o_rank_index),
        .o_bankgroup_index (o_bankgroup_index),
        .o_bank_index      (o_bank_index),
        .o_row_index       (o_row_index),
        .o_column_index    (o_column_index)
    );

endmodule

`default_nettype wire

/* rtl/core/pbpi_checker.sv */
// Port-level checks of the address mapper and the bind that attaches them.
`default_nettype none

`include "assert_macros.svh"

module pbpi_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_valid,
    input wire logic                            o_stall,
    input wire logic                            o_valid,
    input wire logic                            i_stall,
    input wire logic [pbpi_pkg::CH_W-1:0]       o_channel_index,
    input wire logic [pbpi_pkg::RK_W-1:0]       o_rank_index,
    input wire logic [pbpi_pkg::BG_W-1:0]       o_bankgroup_index,
    input wire logic [pbpi_pkg::BK_W-1:0]       o_bank_index,
    input wire logic [pbpi_pkg::ROW_W-1:0]      o_row_index,
    input wire logic [pbpi_pkg::COL_W-1:0]      o_column_index
);

    `PBPI_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable({o_channel_index, o_rank_index, o_bankgroup_index, o_bank_index, o_row_index, o_column_index}), "stalled output word changed")

    `PBPI_ASSERT_ALWAYS(a_stall_needs_full, i_clk, o_stall |-> o_valid, "input stalled with an empty output stage")

    `PBPI_ASSERT(a_latency, i_clk, i_rst_n, (i_valid && !o_stall) ##1 !i_stall ##1 !i_stall |=> o_valid, "accepted word did not reach the output in three cycles")

endmodule

bind pbpi_dram_address_mapper_top pbpi_checker u_pbpi_checker (.*);

`default_nettype wire
